// File: sv/qxm_pkg.sv
`default_nettype none
package qxm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int PROD_W = 64;
  localparam int RPY_W = 48;
  localparam int SUM_W = 50;
  localparam int RAD_W = 48;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SQRT_BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_BITS_PER_STAGE;
  localparam int LATENCY = SQRT_STAGES + 7;

  localparam logic signed [63:0] ARG_K0 = 64'sd740012661;
  localparam logic signed [32:0] ARG_K1 = 33'sd2952072072;
  localparam logic [24:0] PWM_K0 = 25'd269838;
  localparam logic [10:0] PWM_LO = 11'd1000;
  localparam logic [10:0] PWM_HI = 11'd2000;

  localparam logic [30:0] RST_ROLL_PITCH_GAIN = 31'd370727;
  localparam logic [30:0] RST_YAW_GAIN = 31'd4096000;
  localparam logic signed [31:0] RST_THRUST_MIN = 32'sd0;
  localparam logic signed [31:0] RST_THRUST_MAX = 32'sd655360;

  typedef enum logic [1:0] {
    REG_ROLL_PITCH_GAIN = 2'd0,
    REG_YAW_GAIN        = 2'd1,
    REG_THRUST_MIN      = 2'd2,
    REG_THRUST_MAX      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] total_force;
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] thrust_one;
    logic signed [31:0] thrust_two;
    logic signed [31:0] thrust_three;
    logic signed [31:0] thrust_four;
    logic [10:0] pwm_one;
    logic [10:0] pwm_two;
    logic [10:0] pwm_three;
    logic [10:0] pwm_four;
  } mot_t;

endpackage
`default_nettype wire

// File: sv/qxm_sqrt.sv
`default_nettype none
module qxm_sqrt
  import qxm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RAD_W-1:0]  rad,
  output logic      [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  n_q    [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  n_in;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [RAD_W-1:0]  n_next;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = rad;
    end else begin : g_rest
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign n_in    = n_q[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] cand;
      logic [REM_W:0]   trial;
      rem_next  = rem_in;
      root_next = root_in;
      n_next    = n_in;
      for (int j = 0; j < SQRT_BITS_PER_STAGE; j++) begin
        cand  = {rem_next[REM_W-3:0], n_next[RAD_W-1 -: 2]};
        trial = {1'b0, cand} - {2'b00, root_next, 2'b01};
        if (!trial[REM_W]) begin
          rem_next  = trial[REM_W-1:0];
          root_next = {root_next[ROOT_W-2:0], 1'b1};
        end else begin
          rem_next  = cand;
          root_next = {root_next[ROOT_W-2:0], 1'b0};
        end
        n_next = {n_next[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= rem_next;
        root_q[g] <= root_next;
        n_q[g]    <= n_next;
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

// File: sv/qxm_lane.sv
`default_nettype none
module qxm_lane
  import qxm_pkg::*;
#(
  parameter bit NEG_R = 1'b0,
  parameter bit NEG_P = 1'b0,
  parameter bit NEG_Y = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [31:0]      f,
  input  wire logic signed [RPY_W-1:0] r,
  input  wire logic signed [RPY_W-1:0] p,
  input  wire logic signed [RPY_W-1:0] y,
  input  wire logic signed [31:0]      thrust_min,
  input  wire logic signed [31:0]      thrust_max,
  output logic signed [31:0]           thrust,
  output logic [10:0]                  pwm
);

  localparam int DLY = SQRT_STAGES + 3;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [31:0]       clamped;
  logic signed [31:0]       clamped_next;
  logic signed [PROD_W-1:0] prod;
  logic [RAD_W-1:0]         rad;
  logic [RAD_W-1:0]         rad_next;
  logic [ROOT_W-1:0]        root;
  logic signed [31:0]       thr [DLY];
  logic [10:0]              pwm_next;

  always_comb begin
    logic signed [SUM_W-1:0] fe, re, pe, ye;
    fe = SUM_W'(f);
    re = SUM_W'(r);
    pe = SUM_W'(p);
    ye = SUM_W'(y);
    sum_next = fe + (NEG_R ? -re : re) + (NEG_P ? -pe : pe) + (NEG_Y ? -ye : ye);
  end

  always_comb begin
    logic signed [SUM_W-1:0] q;
    q = (sum + SUM_W'(2)) >>> 2;
    if (q < SUM_W'(thrust_min)) q = SUM_W'(thrust_min);
    if (q > SUM_W'(thrust_max)) q = SUM_W'(thrust_max);
    clamped_next = q[31:0];
  end

  always_comb begin
    logic signed [PROD_W-1:0] arg;
    arg = ARG_K0 + (prod >>> FRAC_BITS);
    rad_next = (arg > 0) ? arg[RAD_W-1:0] : '0;
  end

  always_comb begin
    logic [24:0] w;
    logic [16:0] q;
    w = PWM_K0 + 25'(root) + 25'd128;
    q = w[24:8];
    if (q < 17'(PWM_LO))      pwm_next = PWM_LO;
    else if (q > 17'(PWM_HI)) pwm_next = PWM_HI;
    else                      pwm_next = q[10:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum     <= sum_next;
      clamped <= clamped_next;
      prod    <= PROD_W'(clamped * ARG_K1);
      rad     <= rad_next;
      thr[0]  <= clamped;
      for (int i = 1; i < DLY; i++) thr[i] <= thr[i-1];
      pwm     <= pwm_next;
    end
  end

  qxm_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  assign thrust = thr[DLY-1];

endmodule
`default_nettype wire

// File: sv/quad_x_mixer_to_pwm.sv
`default_nettype none
// channel | direction | handshake                  | payload
// cmd     | in        | cmd_valid / cmd_ready      | cmd (cmd_t)
// mot     | out       | mot_valid / mot_ready      | mot (mot_t)
// apb     | in/out    | psel penable pwrite pready | paddr pwdata prdata
// One transaction per cycle unless a result stalls; the root pipeline has 12 stages.
// rst clears the valid pipe and the registers to their defaults.
// A stalled result holds the whole pipe; ready drops only while a result waits.
module quad_x_mixer_to_pwm
  import qxm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_t        cmd,
  output logic             mot_valid,
  input  wire logic        mot_ready,
  output mot_t             mot,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [30:0]        roll_pitch_gain;
  logic [30:0]        yaw_gain;
  logic signed [31:0] thrust_min;
  logic signed [31:0] thrust_max;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_pitch_gain <= RST_ROLL_PITCH_GAIN;
      yaw_gain        <= RST_YAW_GAIN;
      thrust_min      <= RST_THRUST_MIN;
      thrust_max      <= RST_THRUST_MAX;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ROLL_PITCH_GAIN: roll_pitch_gain <= pwdata[30:0];
        REG_YAW_GAIN:        yaw_gain <= pwdata[30:0];
        REG_THRUST_MIN:      thrust_min <= pwdata;
        REG_THRUST_MAX:      thrust_max <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROLL_PITCH_GAIN: prdata = {1'b0, roll_pitch_gain};
      REG_YAW_GAIN:        prdata = {1'b0, yaw_gain};
      REG_THRUST_MIN:      prdata = thrust_min;
      REG_THRUST_MAX:      prdata = thrust_max;
    endcase
  end

  logic [LATENCY-1:0] vpipe;
  logic               en;

  assign en        = !vpipe[LATENCY-1] || mot_ready;
  assign cmd_ready = en;
  assign mot_valid = vpipe[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LATENCY-2:0], cmd_valid};
    end
  end

  logic signed [31:0]       f1, f2;
  logic signed [PROD_W-1:0] pr, pp, py;
  logic signed [RPY_W-1:0]  r2, p2, y2;

  function automatic logic signed [RPY_W-1:0] round_q(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] s;
    s = (x + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return s[RPY_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= cmd.total_force;
      pr <= PROD_W'(cmd.roll_torque * $signed({1'b0, roll_pitch_gain}));
      pp <= PROD_W'(cmd.pitch_torque * $signed({1'b0, roll_pitch_gain}));
      py <= PROD_W'(cmd.yaw_torque * $signed({1'b0, yaw_gain}));
      f2 <= f1;
      r2 <= round_q(pr);
      p2 <= round_q(pp);
      y2 <= round_q(py);
    end
  end

  qxm_lane #(.NEG_R(1'b0), .NEG_P(1'b0), .NEG_Y(1'b0)) u_lane1 (
    .clk(clk), .en(en), .f(f2), .r(r2), .p(p2), .y(y2),
    .thrust_min(thrust_min), .thrust_max(thrust_max),
    .thrust(mot.thrust_one), .pwm(mot.pwm_one)
  );

  qxm_lane #(.NEG_R(1'b1), .NEG_P(1'b0), .NEG_Y(1'b1)) u_lane2 (
    .clk(clk), .en(en), .f(f2), .r(r2), .p(p2), .y(y2),
    .thrust_min(thrust_min), .thrust_max(thrust_max),
    .thrust(mot.thrust_two), .pwm(mot.pwm_two)
  );

  qxm_lane #(.NEG_R(1'b1), .NEG_P(1'b1), .NEG_Y(1'b0)) u_lane3 (
    .clk(clk), .en(en), .f(f2), .r(r2), .p(p2), .y(y2),
    .thrust_min(thrust_min), .thrust_max(thrust_max),
    .thrust(mot.thrust_three), .pwm(mot.pwm_three)
  );

  qxm_lane #(.NEG_R(1'b0), .NEG_P(1'b1), .NEG_Y(1'b1)) u_lane4 (
    .clk(clk), .en(en), .f(f2), .r(r2), .p(p2), .y(y2),
    .thrust_min(thrust_min), .thrust_max(thrust_max),
    .thrust(mot.thrust_four), .pwm(mot.pwm_four)
  );

endmodule
`default_nettype wire

// File: tb/quad_x_mixer_to_pwm_test.sv
`default_nettype none
module quad_x_mixer_to_pwm_test;
  import qxm_pkg::*;

  localparam int Q = 16;
  localparam longint CURVE_K0 = 64'sd740012661;
  localparam longint CURVE_K1 = 64'sd2952072072;
  localparam longint WIDTH_K0 = 64'sd269838;
  localparam longint WIDTH_LO = 64'sd1000;
  localparam longint WIDTH_HI = 64'sd2000;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic mot_valid;
  logic mot_ready;
  mot_t mot;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [30:0] rp_gain;
  logic [30:0] y_gain;
  longint thr_min;
  longint thr_max;

  mot_t motor_q[$];
  int errors;
  int quiet_cycles;
  bit send_gaps;
  bit recv_stalls;
  bit long_hold;

  quad_x_mixer_to_pwm DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .mot_valid(mot_valid), .mot_ready(mot_ready), .mot(mot),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_q(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [10:0] thrust_width(longint t);
    longint arg;
    longint unsigned s;
    longint p;
    arg = CURVE_K0 + ((CURVE_K1 * t) >>> Q);
    s = 0;
    if (arg > 0) s = sqrt_floor(longint'(arg));
    if (s > (64'd1 << 40)) s = 64'd1 << 40;
    p = (WIDTH_K0 + longint'(s) + 128) >>> 8;
    if (p < WIDTH_LO) p = WIDTH_LO;
    if (p > WIDTH_HI) p = WIDTH_HI;
    return 11'(p);
  endfunction

  function automatic mot_t mix_motors(cmd_t c);
    longint f, r, p, y;
    longint t[4];
    logic [10:0] w[4];
    mot_t m;
    f = longint'(c.total_force);
    r = round_q(longint'(c.roll_torque) * longint'({1'b0, rp_gain}), Q);
    p = round_q(longint'(c.pitch_torque) * longint'({1'b0, rp_gain}), Q);
    y = round_q(longint'(c.yaw_torque) * longint'({1'b0, y_gain}), Q);
    t[0] = f + r + p + y;
    t[1] = f - r + p - y;
    t[2] = f - r - p + y;
    t[3] = f + r - p - y;
    for (int i = 0; i < 4; i++) begin
      t[i] = round_q(t[i], 2);
      if (t[i] < thr_min) t[i] = thr_min;
      if (t[i] > thr_max) t[i] = thr_max;
      w[i] = thrust_width(t[i]);
    end
    m.thrust_one = 32'(t[0]);
    m.thrust_two = 32'(t[1]);
    m.thrust_three = 32'(t[2]);
    m.thrust_four = 32'(t[3]);
    m.pwm_one = w[0];
    m.pwm_two = w[1];
    m.pwm_three = w[2];
    m.pwm_four = w[3];
    return m;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROLL_PITCH_GAIN: rp_gain = v[30:0];
      REG_YAW_GAIN: y_gain = v[30:0];
      REG_THRUST_MIN: thr_min = longint'(signed'(v));
      REG_THRUST_MAX: thr_max = longint'(signed'(v));
    endcase
  endtask

  task automatic drain;
    while (motor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [31:0] rpg, logic [31:0] yg, logic [31:0] lo,
                            logic [31:0] hi);
    drain();
    write_reg(REG_ROLL_PITCH_GAIN, rpg);
    write_reg(REG_YAW_GAIN, yg);
    write_reg(REG_THRUST_MIN, lo);
    write_reg(REG_THRUST_MAX, hi);
  endtask

  task automatic send_wrench(cmd_t c);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    motor_q.push_back(mix_motors(c));
  endtask

  task automatic end_burst;
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 2600000)) - 32'd1300000;
      2: return 32'($urandom_range(0, 200000)) - 32'd100000;
      default: return 32'($urandom_range(0, 40000)) - 32'd20000;
    endcase
  endfunction

  function automatic cmd_t random_wrench();
    cmd_t c;
    c.total_force = $urandom_range(0, 1) ? pick_field()
                                         : 32'($urandom_range(0, 2000000)) - 32'd300000;
    c.roll_torque = pick_field();
    c.pitch_torque = pick_field();
    c.yaw_torque = $urandom_range(0, 1) ? pick_field() : 32'($urandom_range(0, 2000)) - 32'd1000;
    return c;
  endfunction

  function automatic logic [31:0] random_gain();
    case ($urandom_range(0, 3))
      0: return {1'b0, 31'($urandom())};
      1: return 32'($urandom_range(0, 600000));
      2: return 32'($urandom_range(0, 8000000));
      default: return 32'($urandom_range(0, 100000));
    endcase
  endfunction

  task automatic test_directed;
    cmd_t c;
    c = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
    send_wrench(c);
    c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    send_wrench(c);
    c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    send_wrench(c);
    c = '{32'sd655360, 32'sd6554, -32'sd6554, 32'sd100};
    send_wrench(c);
    end_burst();
    // wide clamp: negative root argument and saturated width
    set_limits(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    c = '{-32'sd65536, 32'sd0, 32'sd0, 32'sd0};
    send_wrench(c);
    c = '{32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0};
    send_wrench(c);
    c = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    send_wrench(c);
    c = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_wrench(c);
    c = '{-32'sd16384, 32'sd1, -32'sd1, 32'sd1};
    send_wrench(c);
    end_burst();
    // inverted clamp and zero gains
    set_limits(32'd0, 32'd0, 32'd400000, -32'd400000);
    c = '{32'sd1000000, 32'sd5, 32'sd5, 32'sd5};
    send_wrench(c);
    c = '{-32'sd1000000, 32'sd5, 32'sd5, 32'sd5};
    send_wrench(c);
    end_burst();
    set_limits(32'd370727, 32'd4096000, 32'd0, 32'd655360);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (send_gaps && k % 100 == 0) begin
        end_burst();
        case ($urandom_range(0, 3))
          0: set_limits(random_gain(), random_gain(), 32'd0, 32'd655360);
          1: set_limits(random_gain(), random_gain(), 32'h80000000, 32'h7fffffff);
          2: set_limits(random_gain(), random_gain(), $urandom(), $urandom());
          default: set_limits(random_gain(), random_gain(),
                              -32'($urandom_range(0, 200000)),
                              32'($urandom_range(0, 3000000)));
        endcase
      end
      send_wrench(random_wrench());
    end
    end_burst();
  endtask

  task automatic test_backpressure;
    set_limits(32'd370727, 32'd4096000, 32'h80000000, 32'h7fffffff);
    long_hold = 1'b1;
    for (int k = 0; k < 80; k++) send_wrench(random_wrench());
    end_burst();
  endtask

  always @(posedge clk) begin
    if (!rst && mot_valid && mot_ready) begin
      if (motor_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        mot_t e;
        e = motor_q.pop_front();
        if (mot.thrust_one !== e.thrust_one) begin
          $error("thrust_one exp %0d got %0d", e.thrust_one, mot.thrust_one); errors++;
        end
        if (mot.thrust_two !== e.thrust_two) begin
          $error("thrust_two exp %0d got %0d", e.thrust_two, mot.thrust_two); errors++;
        end
        if (mot.thrust_three !== e.thrust_three) begin
          $error("thrust_three exp %0d got %0d", e.thrust_three, mot.thrust_three); errors++;
        end
        if (mot.thrust_four !== e.thrust_four) begin
          $error("thrust_four exp %0d got %0d", e.thrust_four, mot.thrust_four); errors++;
        end
        if (mot.pwm_one !== e.pwm_one) begin
          $error("pwm_one exp %0d got %0d", e.pwm_one, mot.pwm_one); errors++;
        end
        if (mot.pwm_two !== e.pwm_two) begin
          $error("pwm_two exp %0d got %0d", e.pwm_two, mot.pwm_two); errors++;
        end
        if (mot.pwm_three !== e.pwm_three) begin
          $error("pwm_three exp %0d got %0d", e.pwm_three, mot.pwm_three); errors++;
        end
        if (mot.pwm_four !== e.pwm_four) begin
          $error("pwm_four exp %0d got %0d", e.pwm_four, mot.pwm_four); errors++;
        end
      end
    end
  end

  initial begin
    mot_ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        mot_ready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
        mot_ready <= 1'b1;
        @(posedge clk);
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        mot_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        mot_ready <= 1'b1;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (mot_valid && mot_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    long_hold = 1'b0;
    rp_gain = RST_ROLL_PITCH_GAIN;
    y_gain = RST_YAW_GAIN;
    thr_min = 0;
    thr_max = 655360;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(910);
    drain();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    test_random(250);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
